// ===== rtl/core/cdc_pkg.sv =====
`timescale 1ns / 1ps
package cdc_pkg;
  localparam int unsigned DnatDepthDefault   = 16;
  localparam int unsigned BypassDepthDefault = 16;
  localparam logic [7:0]  DnsOctetReset      = 8'd224;
  localparam logic [15:0] MappedTag          = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_CLASSIFY = 2'd0,
    KIND_DNAT_WR  = 2'd1,
    KIND_BYP_WR   = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_PROXY  = 2'd0,
    VERDICT_DIRECT = 2'd1,
    VERDICT_REFUSE = 2'd2,
    VERDICT_WRITE  = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    CFG_DNAT_USED   = 2'd0,
    CFG_BYPASS_USED = 2'd1,
    CFG_DNS_OCTET   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    logic        is_v6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port_num;
    logic [31:0] rewrite_addr;
    logic [15:0] rewrite_port;
    logic [7:0]  prefix_len;
    logic [31:0] v4_mask;
  } in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        out_is_v6;
    logic [63:0] out_addr_high;
    logic [63:0] out_addr_low;
    logic [15:0] out_port;
    logic        dnat_hit;
    logic        dns_pseudo;
  } out_t;

  // Normalized classify item after the first stage.
  typedef struct packed {
    logic        is_write;
    logic        refused;
    logic        dns;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
  } norm_t;

  // Mask of the top p bits of a 128-bit address, p clamped to 128.
  function automatic logic [127:0] prefix_mask(input logic [7:0] p);
    logic [7:0] pc;
    pc = (p > 8'd128) ? 8'd128 : p;
    if (pc == 8'd0) return '0;
    return ~(128'h0) << (8'd128 - pc);
  endfunction
endpackage

// ===== rtl/core/cdc_stream_if.sv =====
`timescale 1ns / 1ps
interface cdc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cdc_cfg_if.sv =====
`timescale 1ns / 1ps
interface cdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/connect_destination_classifier.sv =====
`timescale 1ns / 1ps
// Each accepted input beat is registered by every stage below before its result beat leaves.
// Throughput: one beat per cycle; the three stages (normalize, DNAT search,
// bypass search) advance together and freeze as a whole while the output stalls.
// Reset clears stage valid bits and configuration registers (DNS octet to 224);
// table contents are undefined until written and need no clearing pass.
module connect_destination_classifier import cdc_pkg::*; #(
  parameter int unsigned DnatDepth   = DnatDepthDefault,
  parameter int unsigned BypassDepth = BypassDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  cdc_stream_if.sink   in_i,
  cdc_stream_if.source out_o,
  cdc_cfg_if.sink      cfg_i
);
  logic [2:0] vld_q, vld_d;
  logic       adv;
  logic [4:0] dnat_used_q, byp_used_q;
  logic [7:0] dns_oct_q;
  in_t        item;
  in_t        item1_q;
  norm_t      n_d, n1_q, n2;
  logic [63:0] olo;
  logic [15:0] oport;
  logic        hit;
  logic        v6, refused;
  logic [63:0] hi, lo;

  assign item = in_i.data;
  // The whole pipe moves when the last stage is empty or being drained.
  assign adv      = !vld_q[2] || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dnat_used_q <= '0;
      byp_used_q  <= '0;
      dns_oct_q   <= DnsOctetReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_DNAT_USED:   dnat_used_q <= cfg_i.wdata[4:0];
        CFG_BYPASS_USED: byp_used_q  <= cfg_i.wdata[4:0];
        CFG_DNS_OCTET:   dns_oct_q   <= cfg_i.wdata[7:0];
        default: ;
      endcase
    end
  end

  // Stage 1: unwrap IPv4-mapped addresses, refuse zero, spot DNS pseudo hosts.
  always_comb begin
    v6 = item.is_v6 && !(item.addr_high == '0 && item.addr_low[63:32] == {16'd0, MappedTag});
    hi = v6 ? item.addr_high : '0;
    lo = v6 ? item.addr_low : {32'd0, item.addr_low[31:0]};
    refused = !v6 && lo[31:0] == '0;
    n_d.is_write = kind_e'(item.kind) != KIND_CLASSIFY;
    n_d.refused  = refused;
    n_d.dns      = !v6 && !refused && lo[31:24] == dns_oct_q;
    n_d.v6       = v6;
    n_d.hi       = hi;
    n_d.lo       = lo;
    n_d.port     = item.port_num;
  end

  // The raw beat rides along one stage so that a bypass write lands in the
  // table exactly between the searches of the beats before and after it.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q    <= n_d;
      item1_q <= item;
    end
  end

  assign vld_d = {vld_q[1:0], in_i.valid};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= vld_d;
  end

  cdc_dnat #(.DnatDepth(DnatDepth)) u_dnat (
    .clk_i, .en_i(adv),
    .wr_i(in_i.valid && adv && kind_e'(item.kind) == KIND_DNAT_WR),
    .wr_idx_i(item.entry_index),
    .wr_match_i({item.addr_low[31:0], item.port_num}),
    .wr_rew_i({item.rewrite_addr, item.rewrite_port}),
    .used_i(dnat_used_q), .n_i(n1_q), .n_o(n2),
    .orig_lo_o(olo), .first_port_o(oport), .hit_o(hit)
  );

  cdc_bypass #(.BypassDepth(BypassDepth)) u_bypass (
    .clk_i, .en_i(adv),
    .wr_i(vld_q[0] && adv && kind_e'(item1_q.kind) == KIND_BYP_WR),
    .wr_item_i(item1_q), .used_i(byp_used_q), .n_i(n2),
    .orig_lo_i(olo), .first_port_i(oport), .hit_i(hit), .res_o(out_o.data)
  );

  assign out_o.valid = vld_q[2];
endmodule

// ===== rtl/core/cdc_dnat.sv =====
`timescale 1ns / 1ps
// Stage 2: parallel DNAT compare, priority pick, rewrite.
module cdc_dnat import cdc_pkg::*; #(
  parameter int unsigned DnatDepth = DnatDepthDefault
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        wr_i,
  input  logic [3:0]  wr_idx_i,
  input  logic [47:0] wr_match_i,
  input  logic [47:0] wr_rew_i,
  input  logic [4:0]  used_i,
  input  norm_t       n_i,
  output norm_t       n_o,
  output logic [63:0] orig_lo_o,
  output logic [15:0] first_port_o,
  output logic        hit_o
);
  localparam int unsigned IdxW = (DnatDepth > 1) ? $clog2(DnatDepth) : 1;

  logic [47:0] match_q [DnatDepth];
  logic [47:0] rew_q   [DnatDepth];
  logic [IdxW-1:0] widx;
  logic        hit_d;
  logic [47:0] rsel;
  norm_t       n_d;

  assign widx = IdxW'(wr_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_i && ({28'd0, wr_idx_i} < DnatDepth)) begin
      match_q[widx] <= wr_match_i;
      rew_q[widx]   <= wr_rew_i;
    end
  end

  always_comb begin
    logic exact_f, wild_f;
    logic [47:0] ex_r, wi_r;
    exact_f = 1'b0;
    wild_f  = 1'b0;
    ex_r    = '0;
    wi_r    = '0;
    for (int i = int'(DnatDepth) - 1; i >= 0; i--) begin
      if (i < int'(used_i) && match_q[i][47:16] == n_i.lo[31:0]) begin
        if (match_q[i][15:0] != 16'd0 && match_q[i][15:0] == n_i.port) begin
          exact_f = 1'b1;
          ex_r    = rew_q[i];
        end
        if (match_q[i][15:0] == 16'd0) begin
          wild_f = 1'b1;
          wi_r   = rew_q[i];
        end
      end
    end
    hit_d = !n_i.v6 && !n_i.dns && !n_i.refused && !n_i.is_write && (exact_f || wild_f);
    rsel  = exact_f ? ex_r : wi_r;
    n_d   = n_i;
    if (hit_d) begin
      n_d.lo = {32'd0, rsel[47:16]};
      if (rsel[15:0] != 16'd0) n_d.port = rsel[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o          <= n_d;
      orig_lo_o    <= n_i.lo;
      first_port_o <= n_i.port;
      hit_o        <= hit_d;
    end
  end
endmodule

// ===== rtl/core/cdc_bypass.sv =====
`timescale 1ns / 1ps
// Stage 3: parallel local-network compare and result assembly.
module cdc_bypass import cdc_pkg::*; #(
  parameter int unsigned BypassDepth = BypassDepthDefault
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        wr_i,
  input  in_t         wr_item_i,
  input  logic [4:0]  used_i,
  input  norm_t       n_i,
  input  logic [63:0] orig_lo_i,
  input  logic [15:0] first_port_i,
  input  logic        hit_i,
  output out_t        res_o
);
  localparam int unsigned IdxW = (BypassDepth > 1) ? $clog2(BypassDepth) : 1;

  logic [63:0]  hi_q   [BypassDepth];
  logic [63:0]  lo_q   [BypassDepth];
  logic [56:0]  attr_q [BypassDepth];
  logic [IdxW-1:0] widx;
  logic         match;
  out_t         res_d;

  assign widx = IdxW'(wr_item_i.entry_index);

  always_ff @(posedge clk_i) begin
    if (wr_i && ({28'd0, wr_item_i.entry_index} < BypassDepth)) begin
      hi_q[widx]   <= wr_item_i.addr_high;
      lo_q[widx]   <= wr_item_i.addr_low;
      attr_q[widx] <= {wr_item_i.v4_mask,
        wr_item_i.prefix_len, wr_item_i.is_v6, wr_item_i.port_num};
    end
  end

  always_comb begin
    logic [127:0] pm;
    match = 1'b0;
    for (int i = 0; i < int'(BypassDepth); i++) begin
      pm = prefix_mask(attr_q[i][24:17]);
      if (i < int'(used_i) && (attr_q[i][15:0] == 16'd0 || attr_q[i][15:0] == n_i.port)
          && attr_q[i][16] == n_i.v6) begin
        if (n_i.v6) begin
          if ((({n_i.hi, n_i.lo} ^ {hi_q[i], lo_q[i]}) & pm) == '0) match = 1'b1;
        end else if (((n_i.lo[31:0] ^ lo_q[i][31:0]) & attr_q[i][56:25]) == '0) begin
          match = 1'b1;
        end
      end
    end
    res_d = '0;
    if (n_i.is_write) begin
      res_d.verdict = VERDICT_WRITE;
    end else if (n_i.refused) begin
      res_d.verdict  = VERDICT_REFUSE;
      res_d.out_port = n_i.port;
    end else if (n_i.dns) begin
      res_d.verdict      = VERDICT_PROXY;
      res_d.out_addr_low = n_i.lo;
      res_d.out_port     = n_i.port;
      res_d.dns_pseudo   = 1'b1;
    end else if (match) begin
      res_d.verdict       = VERDICT_DIRECT;
      res_d.out_is_v6     = n_i.v6;
      res_d.out_addr_high = n_i.hi;
      res_d.out_addr_low  = orig_lo_i;
      res_d.out_port      = first_port_i;
    end else begin
      res_d.verdict       = VERDICT_PROXY;
      res_d.out_is_v6     = n_i.v6;
      res_d.out_addr_high = n_i.hi;
      res_d.out_addr_low  = n_i.lo;
      res_d.out_port      = n_i.port;
      res_d.dnat_hit      = hit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_o <= res_d;
  end
endmodule

// ===== rtl/core/cdc_checker.sv =====
`timescale 1ns / 1ps
module cdc_checker import cdc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result moved");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("stalled while output empty");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid) else $error("result lost");
  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.verdict == VERDICT_REFUSE |-> out_data.out_addr_low == '0)
    else $error("refused with address");
endmodule

bind connect_destination_classifier cdc_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import cdc_pkg::*;

  // The clock and the reset. Reset is held low at the start of the run and
  // is never asserted again.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  // One interface instance per channel: input beats, result beats, and
  // register writes.
  cdc_stream_if #(.T(in_t)) in_ch ();
  cdc_stream_if #(.T(out_t)) out_ch ();
  cdc_cfg_if cfg_ch ();

  connect_destination_classifier DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch)
  );

  // The testbench keeps its own copy of the configuration and the tables.
  // An entry is only searched once the matching count register says so, and
  // the stimulus only raises a count after that entry has been written.
  logic [4:0]  dnat_used;
  logic [4:0]  byp_used;
  logic [7:0]  dns_octet;
  logic [47:0] dnat_match_tab [16];
  logic [47:0] dnat_rewr_tab [16];
  logic [63:0] byp_hi_tab [16];
  logic [63:0] byp_lo_tab [16];
  logic        byp_v6_tab [16];
  logic [15:0] byp_port_tab [16];
  logic [7:0]  byp_pfx_tab [16];
  logic [31:0] byp_mask_tab [16];

  // Expected verdicts wait here in the order in which their inputs went in.
  out_t verdict_q[$];
  int   errors = 0;
  int   cycles = 0;

  // Percentages of cycles in which the sender and the receiver sit idle.
  int send_idle_pct = 18;
  int recv_idle_pct = 45;

  // Addresses kept from earlier writes, so that random classifies hit the
  // DNAT table often enough.
  logic [31:0] dnat_addr_pool [16];
  logic [15:0] dnat_port_pool [16];

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("tb: mismatch in %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Works out the result of one classify, or the write answer, and updates
  // the local tables for writes.
  function automatic out_t classify_dest(input in_t it);
    out_t        r;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
    logic [31:0] orig_a4;
    logic [15:0] first_port;
    logic        hit;
    int          hidx;
    int          n;
    logic [127:0] pm;
    logic [7:0]  p;
    r = '0;
    if (it.kind != KIND_CLASSIFY) begin
      r.verdict = VERDICT_WRITE;
      if (it.kind == KIND_DNAT_WR) begin
        dnat_match_tab[it.entry_index] = {it.addr_low[31:0], it.port_num};
        dnat_rewr_tab[it.entry_index] = {it.rewrite_addr, it.rewrite_port};
      end else if (it.kind == KIND_BYP_WR) begin
        byp_hi_tab[it.entry_index] = it.addr_high;
        byp_lo_tab[it.entry_index] = it.addr_low;
        byp_v6_tab[it.entry_index] = it.is_v6;
        byp_port_tab[it.entry_index] = it.port_num;
        byp_pfx_tab[it.entry_index] = it.prefix_len;
        byp_mask_tab[it.entry_index] = it.v4_mask;
      end
      return r;
    end
    v6 = it.is_v6;
    hi = it.addr_high;
    lo = it.addr_low;
    port = it.port_num;
    // An IPv4-mapped IPv6 address is handled as plain IPv4.
    if (v6 && hi == '0 && lo[63:32] == {16'h0, MappedTag}) v6 = 1'b0;
    if (!v6) begin
      hi = '0;
      lo = {32'h0, lo[31:0]};
      if (lo == '0) begin
        r.verdict = VERDICT_REFUSE;
        r.out_port = port;
        return r;
      end
    end
    orig_a4 = lo[31:0];
    first_port = port;
    if (!v6 && lo[31:24] == dns_octet) begin
      r.verdict = VERDICT_PROXY;
      r.out_addr_low = lo;
      r.out_port = port;
      r.dns_pseudo = 1'b1;
      return r;
    end
    hit = 1'b0;
    hidx = 0;
    if (!v6) begin
      n = (dnat_used > 16) ? 16 : dnat_used;
      // Exact address and port first, then the wildcard port entries.
      for (int i = 0; i < n; i++)
        if (!hit && dnat_match_tab[i][47:16] == lo[31:0] && dnat_match_tab[i][15:0] != 0
            && dnat_match_tab[i][15:0] == port) begin
          hit = 1'b1;
          hidx = i;
        end
      for (int i = 0; i < n; i++)
        if (!hit && dnat_match_tab[i][47:16] == lo[31:0] && dnat_match_tab[i][15:0] == 0) begin
          hit = 1'b1;
          hidx = i;
        end
      if (hit) begin
        lo = {32'h0, dnat_rewr_tab[hidx][47:16]};
        if (dnat_rewr_tab[hidx][15:0] != 0) port = dnat_rewr_tab[hidx][15:0];
      end
    end
    n = (byp_used > 16) ? 16 : byp_used;
    for (int i = 0; i < n; i++) begin
      if (byp_port_tab[i] != 0 && byp_port_tab[i] != port) continue;
      if (byp_v6_tab[i] != v6) continue;
      if (v6) begin
        p = (byp_pfx_tab[i] > 128) ? 8'd128 : byp_pfx_tab[i];
        pm = (p == 0) ? '0 : ~(128'h0) << (128 - p);
        if ((({hi, lo} ^ {byp_hi_tab[i], byp_lo_tab[i]}) & pm) != '0) continue;
      end else if (((lo[31:0] ^ byp_lo_tab[i][31:0]) & byp_mask_tab[i]) != '0) continue;
      // Direct: the original destination, with no DNAT flag.
      r.verdict = VERDICT_DIRECT;
      r.out_is_v6 = v6;
      r.out_addr_high = v6 ? hi : '0;
      r.out_addr_low = v6 ? lo : {32'h0, orig_a4};
      r.out_port = first_port;
      return r;
    end
    r.verdict = VERDICT_PROXY;
    r.out_is_v6 = v6;
    r.out_addr_high = hi;
    r.out_addr_low = lo;
    r.out_port = port;
    r.dnat_hit = hit;
    return r;
  endfunction

  // The receiver side. Ready is driven at the rising edge, and each result
  // beat is compared against the oldest expectation field by field.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report("unexpected beat", 64'(out_ch.data.verdict), 64'd0);
        end else begin
          automatic out_t w = verdict_q.pop_front();
          automatic out_t g = out_ch.data;
          if (g.verdict !== w.verdict)
            report("verdict", 64'(g.verdict), 64'(w.verdict));
          if (g.out_is_v6 !== w.out_is_v6)
            report("out_is_v6", 64'(g.out_is_v6), 64'(w.out_is_v6));
          if (g.out_addr_high !== w.out_addr_high)
            report("out_addr_high", g.out_addr_high, w.out_addr_high);
          if (g.out_addr_low !== w.out_addr_low)
            report("out_addr_low", g.out_addr_low, w.out_addr_low);
          if (g.out_port !== w.out_port)
            report("out_port", 64'(g.out_port), 64'(w.out_port));
          if (g.dnat_hit !== w.dnat_hit)
            report("dnat_hit", 64'(g.dnat_hit), 64'(w.dnat_hit));
          if (g.dns_pseudo !== w.dns_pseudo)
            report("dns_pseudo", 64'(g.dns_pseudo), 64'(w.dns_pseudo));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The watchdog: a correct run takes far fewer cycles than this.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sends one input beat, with random idle cycles before it. Valid stays up
  // after the beat is taken until the next idle cycle or the next beat.
  task automatic send_item(input in_t it, input logic check_typed, input out_t typed);
    out_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    exp_r = classify_dest(it);
    if (check_typed && exp_r !== typed) report("directed row", exp_r[63:0], typed[63:0]);
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    verdict_q.push_back(exp_r);
  endtask

  // Writes one register. The block is idle whenever this is called.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_DNAT_USED:   dnat_used = val[4:0];
      CFG_BYPASS_USED: byp_used = val[4:0];
      default:         dns_octet = val[7:0];
    endcase
  endtask

  // Waits until every expected result has arrived, then for longer than the pipeline depth.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic in_t rand_bits();
    in_t it;
    it.kind = KIND_CLASSIFY;
    it.entry_index = 4'($urandom);
    it.is_v6 = 1'($urandom);
    it.addr_high = {$urandom, $urandom};
    it.addr_low = {$urandom, $urandom};
    it.port_num = 16'($urandom);
    it.rewrite_addr = $urandom;
    it.rewrite_port = 16'($urandom);
    it.prefix_len = 8'($urandom_range(255));
    it.v4_mask = $urandom;
    return it;
  endfunction

  // A random classify shaped to land on table entries, mapped addresses,
  // the DNS subnet, zero addresses and plain noise.
  function automatic in_t rand_classify();
    in_t it;
    int  e;
    it = rand_bits();
    e = $urandom_range(15);
    case ($urandom_range(9))
      0, 1, 2: begin
        it.is_v6 = 1'b0;
        it.addr_low[31:0] = dnat_addr_pool[e];
        if ($urandom_range(1)) it.port_num = dnat_port_pool[e];
      end
      3: begin
        it.is_v6 = 1'b1;
        it.addr_high = '0;
        it.addr_low[63:32] = {16'h0, MappedTag};
        if ($urandom_range(1)) it.addr_low[31:0] = dnat_addr_pool[e];
      end
      4: begin
        it.is_v6 = byp_v6_tab[e];
        it.addr_high = byp_hi_tab[e] ^ (64'h1 << $urandom_range(63));
        it.addr_low = byp_lo_tab[e] ^ (64'h1 << $urandom_range(63));
        if ($urandom_range(1)) it.port_num = byp_port_tab[e];
      end
      5: begin
        it.is_v6 = 1'b0;
        it.addr_low[31:24] = dns_octet;
      end
      6: if ($urandom_range(3) == 0) it.addr_low[31:0] = '0;
      default: ;
    endcase
    return it;
  endfunction

  // Directed rows: stimulus and, where it is plain, the typed-in result.
  typedef struct {
    in_t  stim;
    logic typed;
    out_t want;
  } row_t;

  initial begin
    row_t rows[$];
    row_t rw;
    in_t  it;
    out_t wr;
    int   phase;

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_DNAT_USED;
    cfg_ch.wdata = '0;
    dnat_used = 0;
    byp_used = 0;
    dns_octet = DnsOctetReset;
    for (int i = 0; i < 16; i++) begin
      dnat_addr_pool[i] = '0;
      dnat_port_pool[i] = '0;
      byp_v6_tab[i] = 1'b0;
      byp_hi_tab[i] = '0;
      byp_lo_tab[i] = '0;
      byp_port_tab[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    wr = '0;
    wr.verdict = VERDICT_WRITE;

    // After reset nothing is searched: a refused zero address, a DNS pseudo
    // address at the reset octet, and a plain proxy at the field extremes.
    it = '0;
    it.port_num = 16'hFFFF;
    rw.stim = it;
    rw.typed = 1'b1;
    rw.want = '0;
    rw.want.verdict = VERDICT_REFUSE;
    rw.want.out_port = 16'hFFFF;
    rows.push_back(rw);
    it = '0;
    it.addr_low = {32'hFFFF_FFFF, 8'd224, 24'h000001};
    it.addr_high = '1;
    rw.stim = it;
    rw.want = '0;
    rw.want.out_addr_low = {32'h0, 8'd224, 24'h000001};
    rw.want.dns_pseudo = 1'b1;
    rows.push_back(rw);
    it = '1;
    it.kind = KIND_CLASSIFY;
    rw.stim = it;
    rw.want = '0;
    rw.want.out_is_v6 = 1'b1;
    rw.want.out_addr_high = '1;
    rw.want.out_addr_low = '1;
    rw.want.out_port = 16'hFFFF;
    rows.push_back(rw);
    // A mapped IPv6 address with a zero IPv4 part is refused too.
    it = '0;
    it.is_v6 = 1'b1;
    it.addr_low = {16'h0, MappedTag, 32'h0};
    rw.stim = it;
    rw.want = '0;
    rw.want.verdict = VERDICT_REFUSE;
    rows.push_back(rw);
    // The unused kind answers like a write and changes nothing.
    it = '1;
    it.kind = KIND_UNUSED;
    rw.stim = it;
    rw.want = wr;
    rows.push_back(rw);

    // Table writes. Entry 0 matches address and port, entry 1 the same
    // address with a wildcard, entry 2 rewrites with a zero port.
    for (int i = 0; i < 16; i++) begin
      it = rand_bits();
      it.kind = KIND_DNAT_WR;
      it.entry_index = 4'(i);
      it.addr_low[31:0] = (i < 2) ? 32'h0A00_0001 : $urandom;
      it.port_num = (i == 1 || i == 2) ? 16'h0 : 16'($urandom);
      if (i == 0) it.port_num = 16'd80;
      if (i == 2) it.rewrite_port = 16'h0;
      dnat_addr_pool[i] = it.addr_low[31:0];
      dnat_port_pool[i] = it.port_num;
      rw.stim = it;
      rw.want = wr;
      rows.push_back(rw);
    end
    foreach (rows[k]) send_item(rows[k].stim, rows[k].typed, rows[k].want);
    rows.delete();
    for (int i = 0; i < 16; i++) begin
      it = rand_bits();
      it.kind = KIND_BYP_WR;
      it.entry_index = 4'(i);
      it.is_v6 = i[0];
      if (i < 4) it.port_num = '0;
      if (i == 2) it.v4_mask = 32'hFF00_0000;
      if (i == 3) it.prefix_len = 8'd0;
      if (i == 5) it.prefix_len = 8'd200;
      send_item(it, 1'b1, wr);
    end
    drain();

    // Random phases, each under its own register setting; the idle pattern changes at phases 3 and 6.
    for (phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 18;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: write_reg(CFG_DNAT_USED, 32'd16);
        1: write_reg(CFG_BYPASS_USED, 32'd16);
        2: write_reg(CFG_DNS_OCTET, 32'd0);
        3: write_reg(CFG_DNS_OCTET, 32'd255);
        4: write_reg(CFG_DNAT_USED, 32'd0);
        5: write_reg(CFG_BYPASS_USED, $urandom_range(16));
        6: write_reg(CFG_DNAT_USED, $urandom_range(1, 16));
        7: write_reg(CFG_DNS_OCTET, $urandom_range(255));
        default: write_reg(CFG_BYPASS_USED, 32'd0);
      endcase
      for (int n = 0; n < 105; n++) begin
        if ($urandom_range(9) == 0) begin
          // Rewrite an entry in place, or send the unused kind; written entries stay written.
          it = rand_bits();
          it.kind = kind_e'($urandom_range(1, 3));
          if (it.kind == KIND_DNAT_WR) begin
            dnat_addr_pool[it.entry_index] = it.addr_low[31:0];
            dnat_port_pool[it.entry_index] = it.port_num;
          end
          send_item(it, 1'b0, wr);
        end else begin
          send_item(rand_classify(), 1'b0, wr);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/cdc_pkg.sv
rtl/core/cdc_stream_if.sv
rtl/core/cdc_cfg_if.sv
rtl/core/cdc_dnat.sv
rtl/core/cdc_bypass.sv
rtl/core/connect_destination_classifier.sv
rtl/core/cdc_checker.sv
test/tb.sv
